// ----- sv/zcr_pkg.sv -----
`default_nettype none

package zcr_pkg;

    localparam int MAX_WINDOW  = 64;
    localparam int SAMPLE_BITS = 16;
    localparam int AXES        = 3;
    localparam int CFG_W       = 7;
    localparam int CNT_W       = 7;
    localparam int PTR_W       = $clog2(MAX_WINDOW);
    localparam int LEN_W       = PTR_W + 1;

    typedef logic [SAMPLE_BITS-1:0] t_sample;
    typedef logic [CNT_W-1:0]       t_cnt;
    typedef logic [PTR_W-1:0]       t_ptr;
    typedef logic [LEN_W-1:0]       t_len;
    typedef logic [CFG_W-1:0]       t_cfg;

    // sign class of one sample: zero, positive or negative
    typedef struct packed {
        logic neg;
        logic nz;
    } t_sgn;

    typedef t_sgn [AXES-1:0]             t_signs;
    typedef logic [AXES-1:0][CNT_W-1:0]  t_cnts;

    function automatic t_sgn sgn_of(t_sample v);
        t_sgn s;
        s.neg = v[SAMPLE_BITS-1];
        s.nz  = |v;
        return s;
    endfunction

    function automatic t_len eff_len(t_cfg cfg);
        int v;
        v = int'(cfg);
        if (v == 0) begin
            v = 1;
        end
        if (v > MAX_WINDOW) begin
            v = MAX_WINDOW;
        end
        return LEN_W'(v);
    endfunction

endpackage

`default_nettype wire

// ----- sv/zcr_in_if.sv -----
`default_nettype none

interface zcr_in_if;
    import zcr_pkg::*;

    logic    valid;
    logic    ready;
    t_sample sample_x;
    t_sample sample_y;
    t_sample sample_z;

    modport source (output valid, output sample_x, output sample_y, output sample_z,
                    input ready);
    modport sink   (input valid, input sample_x, input sample_y, input sample_z,
                    output ready);
endinterface

`default_nettype wire

// ----- sv/zcr_out_if.sv -----
`default_nettype none

interface zcr_out_if;
    import zcr_pkg::*;

    logic valid;
    logic ready;
    t_cnt crossings_x;
    t_cnt crossings_y;
    t_cnt crossings_z;

    modport source (output valid, output crossings_x, output crossings_y,
                    output crossings_z, input ready);
    modport sink   (input valid, input crossings_x, input crossings_y,
                    input crossings_z, output ready);
endinterface

`default_nettype wire

// ----- sv/zcr_sign_ring.sv -----
`default_nettype none

module zcr_sign_ring (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_we,
    input  zcr_pkg::t_ptr   i_waddr,
    input  zcr_pkg::t_signs i_wdata,
    input  logic            i_re,
    input  zcr_pkg::t_ptr   i_raddr,
    output zcr_pkg::t_signs o_rdata
);
    import zcr_pkg::*;

    t_signs                 r_mem [MAX_WINDOW];
    logic [MAX_WINDOW-1:0]  r_vld;
    t_signs                 r_rdata;
    logic                   r_rvld;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    // entries never written read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_rvld <= 1'b0;
        end else begin
            if (i_we) begin
                r_vld[i_waddr] <= 1'b1;
            end
            if (i_re) begin
                r_rvld <= r_vld[i_raddr];
            end
        end
    end

    assign o_rdata = r_rvld ? r_rdata : '0;

endmodule

`default_nettype wire

// ----- sv/zcr_cross_acc.sv -----
`default_nettype none

module zcr_cross_acc (
    input  logic            i_clk,
    input  logic            i_clr,
    input  logic            i_en,
    input  zcr_pkg::t_signs i_a,
    input  zcr_pkg::t_signs i_b,
    output zcr_pkg::t_cnts  o_cnt
);
    import zcr_pkg::*;

    t_cnts r_cnt;
    logic [AXES-1:0] hit;

    always_comb begin
        for (int a = 0; a < AXES; a++) begin
            hit[a] = i_a[a].nz && i_b[a].nz && (i_a[a].neg ^ i_b[a].neg);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int a = 0; a < AXES; a++) begin
            if (i_clr) begin
                r_cnt[a] <= '0;
            end else if (i_en && hit[a] && (r_cnt[a] != '1)) begin
                r_cnt[a] <= r_cnt[a] + 1'b1;
            end
        end
    end

    assign o_cnt = r_cnt;

endmodule

`default_nettype wire

// ----- sv/zero_crossing_rate_three_axis.sv -----
`default_nettype none

// Counts sign changes per axis over a circular window of the last samples. Each
// word written on i_in is stored at the write pointer, then the window is read
// back one entry per cycle through a single compare-and-count unit, and the
// three counts leave on o_out. Each item walks the ring with one read per entry,
// then a drain step covers the read latency, a wrap step adds the last-to-first
// pair and a done step loads the result. The done step holds until the next
// pointer is reduced into the window and no earlier result waits on o_out.
// i_in is ready only between items; a result may wait on o_out while the next
// word is taken. Zero on either side of a pair is not a crossing. The ring reads
// as zero after reset without a clear pass. The user must write window_length
// through i_cfg_we / i_cfg_wdata only while idle; the block does not enforce it.
module zero_crossing_rate_three_axis (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  zcr_pkg::t_cfg i_cfg_wdata,
    zcr_in_if.sink        i_in,
    zcr_out_if.source     o_out
);
    import zcr_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_WALK  = 3'd1;
    localparam logic [2:0] S_DRAIN = 3'd2;
    localparam logic [2:0] S_WRAP  = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;
    t_cfg       r_cfg;
    t_ptr       r_wp;
    t_ptr       r_idx;
    t_ptr       r_last;
    t_len       r_len;
    t_len       r_np;
    logic       r_rd_pend;
    logic       r_rd_first;
    t_signs     r_prev;
    t_signs     r_first;
    logic       r_out_valid;
    t_cnts      r_out_cnt;

    logic       accept;
    logic       np_ok;
    logic       done;
    t_len       len;
    t_signs     wdata;
    t_signs     rd_data;
    logic       acc_en;
    t_signs     acc_b;
    t_cnts      cnt;

    assign accept = i_in.valid && i_in.ready;
    assign np_ok  = r_np < r_len;
    assign len    = eff_len(r_cfg);
    assign done   = (r_state == S_DONE) && (n_state == S_IDLE);

    assign wdata[0] = sgn_of(i_in.sample_x);
    assign wdata[1] = sgn_of(i_in.sample_y);
    assign wdata[2] = sgn_of(i_in.sample_z);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) n_state = S_WALK;
            end
            S_WALK: begin
                if (r_idx == r_last) n_state = S_DRAIN;
            end
            S_DRAIN: n_state = S_WRAP;
            S_WRAP:  n_state = S_DONE;
            S_DONE: begin
                if (np_ok && (!r_out_valid || o_out.ready)) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    zcr_sign_ring u_ring (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (accept),
        .i_waddr (r_wp),
        .i_wdata (wdata),
        .i_re    (r_state == S_WALK),
        .i_raddr (r_idx),
        .o_rdata (rd_data)
    );

    // neighbor pairs while walking, last-to-first pair in the wrap step
    assign acc_en = (r_rd_pend && !r_rd_first) || (r_state == S_WRAP);
    assign acc_b  = (r_state == S_WRAP) ? r_first : rd_data;

    zcr_cross_acc u_acc (
        .i_clk (i_clk),
        .i_clr (accept),
        .i_en  (acc_en),
        .i_a   (r_prev),
        .i_b   (acc_b),
        .o_cnt (cnt)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cfg       <= CFG_W'(64);
            r_wp        <= '0;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rd_pend <= (r_state == S_WALK);
            if (i_cfg_we) begin
                r_cfg <= i_cfg_wdata;
            end
            if (done) begin
                r_wp        <= r_np[PTR_W-1:0];
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_first <= (r_idx == '0);
        if (accept) begin
            r_idx  <= '0;
            r_len  <= len;
            r_last <= PTR_W'(len - 1'b1);
            r_np   <= LEN_W'(r_wp) + 1'b1;
        end else begin
            if ((r_state == S_WALK) && (r_idx != r_last)) begin
                r_idx <= r_idx + 1'b1;
            end
            // next pointer modulo the window by repeated subtract
            if ((r_state != S_IDLE) && !np_ok) begin
                r_np <= r_np - r_len;
            end
        end
        if (r_rd_pend) begin
            r_prev <= rd_data;
            if (r_rd_first) begin
                r_first <= rd_data;
            end
        end
        if (done) begin
            r_out_cnt <= cnt;
        end
    end

    assign i_in.ready        = (r_state == S_IDLE);
    assign o_out.valid       = r_out_valid;
    assign o_out.crossings_x = r_out_cnt[0];
    assign o_out.crossings_y = r_out_cnt[1];
    assign o_out.crossings_z = r_out_cnt[2];

    a_idle_no_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_rd_pend)
        else $error("ring read pending while idle");

    a_accept_starts_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_WALK) && (r_idx == '0))
        else $error("accepted word did not start the window walk");

    a_wp_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        done |=> (LEN_W'(r_wp) < r_len))
        else $error("write pointer left outside the window");

endmodule

`default_nettype wire
